// ===== rtl/core/lgfl_pkg.sv =====
package lgfl_pkg;

	localparam int LEVEL_W = 12;
	localparam int BYTE_W  = 8;

	typedef enum logic [1:0] {
		OP_WRITE_ONE = 2'd0,
		OP_WRITE_ALL = 2'd1,
		OP_COMMIT    = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0F;
	localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hF0;

endpackage

// ===== rtl/core/led_grayscale_frame_loader.sv =====
// Packs 12-bit grayscale levels for an LED driver chain into a shift buffer of
// (3*CHANNELS+1)/2 bytes, last channel first, most significant bit first, two
// channels to three bytes, and plays it out on refresh ticks. One transaction
// is handled at a time and in_stall stays high until it is finished, all with
// the single byte memory port and its registered read. A commit leaves the
// block idle, a single-channel write writes one byte whole and reads and
// merges the shared byte, and a write-all writes one byte per cycle. A
// refresh tick sends its control transaction and, when a commit is pending,
// then every buffer byte (each read, then handed over), stretched by any
// output stall. Per-byte valid flags make the buffer read as zero after
// reset, so there is no clearing pass.
module led_grayscale_frame_loader #(
	parameter int CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [3:0]  channel,
	input  logic [11:0] level,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        control_item,
	output logic        blank_pulse,
	output logic        latch_pulse,
	output logic        extra_clock_pulse,
	output logic        mode_level,
	output logic [7:0]  shift_byte,
	output logic        last
);

	localparam int BUF_BYTES = (CHANNELS * 3 + 1) / 2;
	localparam int AW        = $clog2(BUF_BYTES);
	localparam int WW        = (AW + 1 > 5) ? AW + 1 : 5;
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_BYTES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WONE_RD,
		ST_WONE_MOD,
		ST_WALL,
		ST_TICK_CTRL,
		ST_SEND_RD,
		ST_SEND_WAIT
	} state_t;

	state_t state_q;

	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  full_addr_q;
	logic [lgfl_pkg::LEVEL_W-1:0]   level_q;
	logic                           odd_q;
	logic [1:0]                     pat_q;
	logic                           send_q;
	logic                           commit_pending_q;
	logic                           latch_pending_q;
	logic                           mode_high_q;

	logic                           out_valid_q;
	logic                           control_item_q;
	logic                           blank_pulse_q;
	logic                           latch_pulse_q;
	logic                           extra_clock_pulse_q;
	logic                           mode_level_q;
	logic [lgfl_pkg::BYTE_W-1:0]    shift_byte_q;
	logic                           last_q;

	logic [lgfl_pkg::BYTE_W-1:0]    mem_q [BUF_BYTES];
	logic [BUF_BYTES-1:0]           valid_q;
	logic [lgfl_pkg::BYTE_W-1:0]    rd_data_q;
	logic                           rd_valid_q;
	logic [lgfl_pkg::BYTE_W-1:0]    rd_byte;

	logic                           we;
	logic [AW-1:0]                  waddr;
	logic [lgfl_pkg::BYTE_W-1:0]    wdata;

	logic                           in_accept;
	logic                           out_free;
	logic [WW-1:0]                  ch_ext;
	logic                           ch_in_range;
	logic [WW-1:0]                  rev_idx;
	logic [WW-1:0]                  byte_idx;
	logic [WW-1:0]                  byte_idx_n;
	logic [lgfl_pkg::BYTE_W-1:0]    pat_byte;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid         = out_valid_q;
	assign control_item      = control_item_q;
	assign blank_pulse       = blank_pulse_q;
	assign latch_pulse       = latch_pulse_q;
	assign extra_clock_pulse = extra_clock_pulse_q;
	assign mode_level        = mode_level_q;
	assign shift_byte        = shift_byte_q;
	assign last              = last_q;

	// Channel r in reverse order starts at byte r*3/2.
	assign ch_ext      = WW'(channel);
	assign ch_in_range = (ch_ext < WW'(CHANNELS));
	assign rev_idx     = WW'(CHANNELS - 1) - ch_ext;
	assign byte_idx    = rev_idx + (rev_idx >> 1);
	assign byte_idx_n  = byte_idx + WW'(1);

	assign rd_byte = rd_valid_q ? rd_data_q : '0;

	always_comb begin
		case (pat_q)
			2'd0:    pat_byte = level_q[11:4];
			2'd1:    pat_byte = {level_q[3:0], level_q[11:8]};
			2'd2:    pat_byte = level_q[7:0];
			default: pat_byte = level_q[7:0];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = full_addr_q;
		wdata = '0;
		case (state_q)
			ST_WONE_RD: begin
				we    = 1'b1;
				waddr = full_addr_q;
				wdata = odd_q ? level_q[7:0] : level_q[11:4];
			end
			ST_WONE_MOD: begin
				// The shared byte keeps the nibble that belongs to the neighbor channel.
				we    = 1'b1;
				waddr = addr_q;
				wdata = odd_q ? ((rd_byte & lgfl_pkg::HI_NIBBLE) | {4'b0000, level_q[11:8]})
				              : ((rd_byte & lgfl_pkg::LO_NIBBLE) | {level_q[3:0], 4'b0000});
			end
			ST_WALL: begin
				we    = 1'b1;
				waddr = addr_q;
				wdata = pat_byte;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			addr_q              <= '0;
			full_addr_q         <= '0;
			level_q             <= '0;
			odd_q               <= 1'b0;
			pat_q               <= 2'd0;
			send_q              <= 1'b0;
			commit_pending_q    <= 1'b0;
			latch_pending_q     <= 1'b0;
			mode_high_q         <= 1'b1;
			out_valid_q         <= 1'b0;
			control_item_q      <= 1'b0;
			blank_pulse_q       <= 1'b0;
			latch_pulse_q       <= 1'b0;
			extra_clock_pulse_q <= 1'b0;
			mode_level_q        <= 1'b0;
			shift_byte_q        <= '0;
			last_q              <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						level_q <= level;
						case (operation)
							lgfl_pkg::OP_WRITE_ONE: begin
								if (ch_in_range) begin
									odd_q <= rev_idx[0];
									if (rev_idx[0]) begin
										addr_q      <= byte_idx[AW-1:0];
										full_addr_q <= byte_idx_n[AW-1:0];
									end else begin
										addr_q      <= byte_idx_n[AW-1:0];
										full_addr_q <= byte_idx[AW-1:0];
									end
									state_q <= ST_WONE_RD;
								end
							end
							lgfl_pkg::OP_WRITE_ALL: begin
								addr_q  <= '0;
								pat_q   <= 2'd0;
								state_q <= ST_WALL;
							end
							lgfl_pkg::OP_COMMIT: begin
								commit_pending_q <= 1'b1;
							end
							lgfl_pkg::OP_TICK: begin
								send_q  <= commit_pending_q;
								state_q <= ST_TICK_CTRL;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WONE_RD: begin
					state_q <= ST_WONE_MOD;
				end
				ST_WONE_MOD: begin
					state_q <= ST_IDLE;
				end
				ST_WALL: begin
					pat_q <= (pat_q == 2'd2) ? 2'd0 : pat_q + 2'd1;
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_TICK_CTRL: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						control_item_q      <= 1'b1;
						blank_pulse_q       <= 1'b1;
						latch_pulse_q       <= latch_pending_q;
						extra_clock_pulse_q <= mode_high_q;
						mode_level_q        <= 1'b0;
						shift_byte_q        <= '0;
						last_q              <= !send_q;
						mode_high_q         <= 1'b0;
						latch_pending_q     <= send_q;
						if (send_q) begin
							commit_pending_q <= 1'b0;
							addr_q           <= '0;
							state_q          <= ST_SEND_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SEND_RD: begin
					state_q <= ST_SEND_WAIT;
				end
				ST_SEND_WAIT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						control_item_q      <= 1'b0;
						blank_pulse_q       <= 1'b0;
						latch_pulse_q       <= 1'b0;
						extra_clock_pulse_q <= 1'b0;
						mode_level_q        <= 1'b0;
						shift_byte_q        <= rd_byte;
						last_q              <= (addr_q == LAST_ADDR);
						if (addr_q == LAST_ADDR) begin
							addr_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							addr_q  <= addr_q + AW'(1);
							state_q <= ST_SEND_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_led_grayscale_frame_loader.sv =====
`timescale 1ns / 1ps

module tb_led_grayscale_frame_loader;

	localparam int CHANNELS      = 16;
	localparam int FRAME_BYTES   = (3 * CHANNELS + 1) / 2;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 2 * FRAME_BYTES + 16;
	localparam int RANDOM_ITEMS  = 346;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic                        control_item;
		logic                        blank_pulse;
		logic                        latch_pulse;
		logic                        extra_clock_pulse;
		logic                        mode_level;
		logic [lgfl_pkg::BYTE_W-1:0] shift_byte;
		logic                        last;
	} pin_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [1:0]  operation = lgfl_pkg::OP_WRITE_ONE;
	logic [3:0]  channel   = '0;
	logic [11:0] level     = '0;
	logic        out_stall = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic        control_item;
	logic        blank_pulse;
	logic        latch_pulse;
	logic        extra_clock_pulse;
	logic        mode_level;
	logic [7:0]  shift_byte;
	logic        last;

	// Grayscale frame as the block should hold it, plus its pin state.
	logic [lgfl_pkg::BYTE_W-1:0] gs_frame [FRAME_BYTES];
	logic                        commit_armed;
	logic                        latch_armed;
	logic                        mode_init;
	pin_item_t                   pending_items[$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	int  rx_hold_cycles = 0;
	bit  tx_idle        = 1'b1;
	bit  rx_idle        = 1'b1;

	always #5 clk = ~clk;

	led_grayscale_frame_loader #(
		.CHANNELS(CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.channel(channel),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.control_item(control_item),
		.blank_pulse(blank_pulse),
		.latch_pulse(latch_pulse),
		.extra_clock_pulse(extra_clock_pulse),
		.mode_level(mode_level),
		.shift_byte(shift_byte),
		.last(last)
	);

	function automatic void clear_frame_model();
		for (int i = 0; i < FRAME_BYTES; i++) gs_frame[i] = '0;
		commit_armed = 1'b0;
		latch_armed  = 1'b0;
		mode_init    = 1'b1;
	endfunction

	// Channels are stored last first; an even slot starts on a byte boundary,
	// an odd slot shares its first nibble with the previous channel.
	function automatic void store_channel(int unsigned ch,
			logic [lgfl_pkg::LEVEL_W-1:0] lv);
		int unsigned slot;
		int unsigned idx;
		if (ch >= CHANNELS) return;
		slot = CHANNELS - 1 - ch;
		idx  = slot * 3 / 2;
		if (idx + 1 >= FRAME_BYTES) return;
		if (slot[0] == 1'b0) begin
			gs_frame[idx]     = lv[11:4];
			gs_frame[idx + 1] = (gs_frame[idx + 1] & lgfl_pkg::LO_NIBBLE) | {lv[3:0], 4'h0};
		end else begin
			gs_frame[idx]     = (gs_frame[idx] & lgfl_pkg::HI_NIBBLE) | {4'h0, lv[11:8]};
			gs_frame[idx + 1] = lv[7:0];
		end
	endfunction

	function automatic void store_all_channels(logic [lgfl_pkg::LEVEL_W-1:0] lv);
		logic [lgfl_pkg::BYTE_W-1:0] pattern [3];
		pattern[0] = lv[11:4];
		pattern[1] = {lv[3:0], lv[11:8]};
		pattern[2] = lv[7:0];
		for (int i = 0; i < FRAME_BYTES; i++) gs_frame[i] = pattern[i % 3];
	endfunction

	function automatic void predict_transaction(lgfl_pkg::op_t op, logic [3:0] ch,
			logic [lgfl_pkg::LEVEL_W-1:0] lv);
		pin_item_t ev;
		case (op)
			lgfl_pkg::OP_WRITE_ONE: store_channel(32'(ch), lv);
			lgfl_pkg::OP_WRITE_ALL: store_all_channels(lv);
			lgfl_pkg::OP_COMMIT:    commit_armed = 1'b1;
			lgfl_pkg::OP_TICK: begin
				ev = '0;
				ev.control_item      = 1'b1;
				ev.blank_pulse       = 1'b1;
				ev.latch_pulse       = latch_armed;
				ev.extra_clock_pulse = mode_init;
				ev.last              = !commit_armed;
				pending_items.push_back(ev);
				latch_armed = 1'b0;
				mode_init   = 1'b0;
				if (commit_armed) begin
					for (int i = 0; i < FRAME_BYTES; i++) begin
						ev = '0;
						ev.shift_byte = gs_frame[i];
						ev.last       = (i == FRAME_BYTES - 1);
						pending_items.push_back(ev);
					end
					latch_armed  = 1'b1;
					commit_armed = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void report_mismatch(string what, pin_item_t want,
			pin_item_t seen);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$write("%0t %s: expected ctl=%0b blank=%0b latch=%0b xclk=%0b mode=%0b",
				$realtime, what, want.control_item, want.blank_pulse,
				want.latch_pulse, want.extra_clock_pulse, want.mode_level);
			$write(" byte=%02h last=%0b,", want.shift_byte, want.last);
			$write(" got ctl=%0b blank=%0b latch=%0b xclk=%0b mode=%0b",
				seen.control_item, seen.blank_pulse, seen.latch_pulse,
				seen.extra_clock_pulse, seen.mode_level);
			$display(" byte=%02h last=%0b", seen.shift_byte, seen.last);
		end
	endfunction

	always @(posedge clk) begin : result_check
		pin_item_t seen;
		pin_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen.control_item      = control_item;
			seen.blank_pulse       = blank_pulse;
			seen.latch_pulse       = latch_pulse;
			seen.extra_clock_pulse = extra_clock_pulse;
			seen.mode_level        = mode_level;
			seen.shift_byte        = shift_byte;
			seen.last              = last;
			if (pending_items.size() == 0) begin
				report_mismatch("unexpected transaction", '0, seen);
			end else begin
				want = pending_items.pop_front();
				if (seen !== want) report_mismatch("field mismatch", want, seen);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("led_grayscale_frame_loader regression: fail");
			$finish;
		end
	end

	// Output side: random stalls while rx_idle is set, or a long hold on request.
	initial begin : receiver
		int gap;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				gap = rx_idle ? $urandom_range(0, 3) : 0;
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Called right after the clock rises. in_valid stays high when the next
	// transaction follows without a gap.
	task automatic send_item(input lgfl_pkg::op_t op, input logic [3:0] ch,
			input logic [lgfl_pkg::LEVEL_W-1:0] lv);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		channel   <= ch;
		level     <= lv;
		do @(posedge clk); while (in_stall);
		predict_transaction(op, ch, lv);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_first_ticks();
		send_item(lgfl_pkg::OP_TICK, 4'hF, 12'hFFF);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
	endtask

	task automatic test_cleared_frame();
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
	endtask

	task automatic test_channel_packing();
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd0, 12'hFFF);
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd15, 12'h000);
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd1, 12'hA5C);
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd14, 12'hFFF);
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd7, 12'h5A3);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_COMMIT, 4'hF, 12'hFFF);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
	endtask

	task automatic test_write_all_pattern();
		send_item(lgfl_pkg::OP_WRITE_ALL, 4'h0, 12'hFFF);
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd8, 12'h000);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_WRITE_ALL, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_WRITE_ALL, 4'h0, 12'h123);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
	endtask

	task automatic test_random_traffic();
		int pick;
		lgfl_pkg::op_t op;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Change the idling pattern now and then, including stretches with none.
			if (n % 48 == 0) begin
				tx_idle = ($urandom_range(0, 2) != 0);
				rx_idle = ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 50)      op = lgfl_pkg::OP_WRITE_ONE;
			else if (pick < 60) op = lgfl_pkg::OP_WRITE_ALL;
			else if (pick < 78) op = lgfl_pkg::OP_COMMIT;
			else                op = lgfl_pkg::OP_TICK;
			send_item(op, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// The output is held while a full frame is queued up, so the block has to
	// stall its input until the hold ends.
	task automatic test_output_hold();
		rx_hold_cycles = HOLD_CYCLES;
		send_item(lgfl_pkg::OP_WRITE_ALL, 4'h3, 12'h9E1);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd2, 12'h0F0);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		wait_drained();
	endtask

	task automatic test_pause_for_drain();
		send_item(lgfl_pkg::OP_WRITE_ONE, 4'd11, 12'h7C2);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		wait_drained();
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_COMMIT, 4'h0, 12'h000);
		send_item(lgfl_pkg::OP_TICK, 4'h0, 12'h000);
	endtask

	initial begin
		clear_frame_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_ticks();
		test_cleared_frame();
		test_channel_packing();
		test_write_all_pattern();
		test_random_traffic();
		test_output_hold();
		test_pause_for_drain();
		wait_drained();
		if (mismatch_count == 0 && pending_items.size() == 0) begin
			$display("led_grayscale_frame_loader regression: pass");
		end else begin
			$display("led_grayscale_frame_loader regression: fail");
		end
		$finish;
	end

endmodule
